/* hdl/topic_prefix_subscription_filter_assert.svh */
// -----------------------------------------------------------------------------
// Topic prefix filter assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef TOPIC_PREFIX_SUBSCRIPTION_FILTER_ASSERT_SVH
`define TOPIC_PREFIX_SUBSCRIPTION_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds at every edge
`define TPSF_ASSERT_NOW(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tpsf check failed");

// consequent holds in the cycle after the antecedent
`define TPSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpsf check failed");

`else

`define TPSF_ASSERT_NOW(lbl, expr)
`define TPSF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/tpsf_pkg.sv */
// -----------------------------------------------------------------------------
// Topic prefix filter package
// Defaults, command and status codes, and the cell control structs.
// -----------------------------------------------------------------------------
package tpsf_pkg;

    localparam int CONNECTIONS_DEF = 4;
    localparam int ENTRIES_DEF     = 8;
    localparam int TOPIC_BYTES_DEF = 16;

    localparam logic [7:0] CMD_BYTE_SUB = 8'd1;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_SUB    = 2'd1,
        CMD_UNSUB  = 2'd2,
        CMD_IGNORE = 2'd3
    } tpsf_cmd_t;

    typedef enum logic [2:0] {
        ST_PUBLISHED    = 3'd0,
        ST_SUBSCRIBED   = 3'd1,
        ST_UNSUBSCRIBED = 3'd2,
        ST_NOT_FOUND    = 3'd3,
        ST_REJECTED     = 3'd4,
        ST_IGNORED      = 3'd5
    } tpsf_status_t;

    // per-connection control broadcast to that connection's cells
    typedef struct packed {
        logic pick;          // command byte of a subscribe: claim lowest free slot
        logic cmp;           // compare this byte
        logic exact;         // unsubscribe compare: too-short entries fail
        logic wr;            // store topic byte in the claimed slot
        logic commit_sub;
        logic commit_unsub;
        logic end_msg;
    } tpsf_ctl_t;

    // running result handed from cell to cell along a connection
    typedef struct packed {
        logic free;          // a free slot seen so far
        logic unsub;         // an exact match seen so far
        logic pub;           // a prefix match seen so far
    } tpsf_chain_t;

endpackage

/* hdl/topic_prefix_subscription_filter.sv */
// -----------------------------------------------------------------------------
// Topic prefix subscription filter
// Per-connection subscription table with parallel prefix match of publishes.
// -----------------------------------------------------------------------------
// Takes one message byte per cycle when not stalled, for both control and publish
// messages; the result word of a message is registered and shows on the master
// side in the cycle after its last byte. The input stalls only while that
// output register holds a word not yet taken. Each slot is a cell holding its
// topic in a small memory whose byte is prefetched at the next byte position, so
// the per-byte work is one byte compare in every cell plus a ripple through the
// ENTRIES cells of a connection that finds the lowest free slot, the lowest exact
// match and any prefix match. No clearing pass is needed after reset.
module topic_prefix_subscription_filter
    import tpsf_pkg::*;
#(
    parameter int CONNECTIONS = CONNECTIONS_DEF,
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int TOPIC_BYTES = TOPIC_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [1:0] conn, [9:2] data_byte, rest zero
    input  logic        s_tuser,      // [0] kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [3:0] match_mask, [6:4] status, [7] zero
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data   // validated_mask
);

    `include "topic_prefix_subscription_filter_assert.svh"

    localparam int PW = $clog2(TOPIC_BYTES + 1);
    localparam int AW = TOPIC_BYTES > 1 ? $clog2(TOPIC_BYTES) : 1;

    tpsf_cmd_t     cmd_reg, cmd_fin, cmd_next;
    logic [PW-1:0] pos_reg, pos_fin, pos_next;
    logic          ovf_reg, ovf_fin, ovf_next;
    logic [1:0]    held_reg, held_fin, held_next;
    logic [3:0]    val_reg;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg;

    logic          accept;
    logic          msg_end;
    logic [1:0]    in_conn;
    logic [7:0]    in_byte;
    logic          start;
    logic          cmd_byte;
    logic          topic_byte;
    logic          pub_byte;
    logic          pos_lt;
    logic          conn_ok;
    logic          held_ok;
    logic          free_sel;
    logic          found_sel;
    logic          commit_sub;
    logic          commit_unsub;
    tpsf_status_t  status_fin;
    logic [3:0]    mask_vec;
    logic [AW-1:0] rd_addr;

    logic [CONNECTIONS-1:0] row_free;
    logic [CONNECTIONS-1:0] row_unsub;
    logic [CONNECTIONS-1:0] row_pub;
    tpsf_ctl_t              ctl [CONNECTIONS];
    tpsf_chain_t            chain [CONNECTIONS][ENTRIES + 1];

    assign accept   = s_tvalid && s_tready;
    assign msg_end  = accept && s_tlast;
    assign s_tready = !m_valid_reg || m_tready;
    assign in_conn  = s_tdata[1:0];
    assign in_byte  = s_tdata[9:2];

    assign start      = (cmd_reg == CMD_NONE) && (pos_reg == '0);
    assign cmd_byte   = start && s_tuser;
    assign topic_byte = accept && (cmd_reg != CMD_NONE);
    assign pub_byte   = accept && (cmd_reg == CMD_NONE) && !cmd_byte;
    assign pos_lt     = pos_reg < PW'(TOPIC_BYTES);
    assign conn_ok    = int'(in_conn) < CONNECTIONS;

    always_comb
    begin
        free_sel  = 1'b0;
        found_sel = 1'b0;
        for (int r = 0; r < CONNECTIONS; r++)
        begin
            if ((int'(in_conn) == r) && row_free[r])
            begin
                free_sel = 1'b1;
            end
            if ((int'(held_fin) == r) && row_unsub[r])
            begin
                found_sel = 1'b1;
            end
        end
    end

    // message state after this word, before the end-of-message clear
    always_comb
    begin
        cmd_fin  = cmd_reg;
        pos_fin  = pos_reg;
        ovf_fin  = ovf_reg;
        held_fin = held_reg;
        if (accept)
        begin
            if (cmd_byte)
            begin
                held_fin = in_conn;
                if (!conn_ok || (in_byte > CMD_BYTE_SUB))
                begin
                    cmd_fin = CMD_IGNORE;
                end
                else if (in_byte == CMD_BYTE_SUB)
                begin
                    cmd_fin = CMD_SUB;
                    if (!free_sel)
                    begin
                        ovf_fin = 1'b1;
                    end
                end
                else
                begin
                    cmd_fin = CMD_UNSUB;
                end
            end
            else if (cmd_reg != CMD_NONE)
            begin
                if (cmd_reg != CMD_IGNORE)
                begin
                    if (!pos_lt)
                    begin
                        ovf_fin = 1'b1;
                    end
                    else
                    begin
                        pos_fin = PW'(pos_reg + 1'b1);
                    end
                end
            end
            else if (pos_lt)
            begin
                pos_fin = PW'(pos_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        cmd_next  = msg_end ? CMD_NONE : cmd_fin;
        pos_next  = msg_end ? '0 : pos_fin;
        ovf_next  = msg_end ? 1'b0 : ovf_fin;
        held_next = held_fin;
        rd_addr   = (pos_next < PW'(TOPIC_BYTES)) ? pos_next[AW-1:0] : '0;
    end

    // result of the message ending with this word
    assign held_ok = int'(held_fin) < CONNECTIONS;

    always_comb
    begin
        status_fin   = ST_PUBLISHED;
        commit_sub   = 1'b0;
        commit_unsub = 1'b0;
        if (cmd_fin == CMD_NONE)
        begin
            status_fin = ST_PUBLISHED;
        end
        else if ((cmd_fin == CMD_IGNORE) || !held_ok || !val_reg[held_fin])
        begin
            status_fin = ST_IGNORED;
        end
        else if (ovf_fin || (pos_fin == '0))
        begin
            status_fin = ST_REJECTED;
        end
        else if (cmd_fin == CMD_SUB)
        begin
            status_fin = ST_SUBSCRIBED;
            commit_sub = msg_end;
        end
        else if (found_sel)
        begin
            status_fin   = ST_UNSUBSCRIBED;
            commit_unsub = msg_end;
        end
        else
        begin
            status_fin = ST_NOT_FOUND;
        end
    end

    generate
        for (genvar c = 0; c < 4; c++)
        begin : g_mask
            if (c < CONNECTIONS)
            begin : g_live
                assign mask_vec[c] = row_pub[c] && val_reg[c];
            end
            else
            begin : g_none
                assign mask_vec[c] = 1'b0;
            end
        end

        for (genvar r = 0; r < CONNECTIONS; r++)
        begin : g_row
            logic row_held;

            assign row_held = int'(held_reg) == r;

            always_comb
            begin
                ctl[r].pick = accept && cmd_byte && conn_ok && (int'(in_conn) == r)
                              && (in_byte == CMD_BYTE_SUB);
                ctl[r].cmp  = pos_lt && (pub_byte
                              || (topic_byte && (cmd_reg == CMD_UNSUB) && row_held));
                ctl[r].exact        = cmd_reg == CMD_UNSUB;
                ctl[r].wr           = topic_byte && (cmd_reg == CMD_SUB) && pos_lt
                                      && !ovf_reg && row_held;
                ctl[r].commit_sub   = commit_sub && (int'(held_fin) == r);
                ctl[r].commit_unsub = commit_unsub && (int'(held_fin) == r);
                ctl[r].end_msg      = msg_end;
            end

            assign chain[r][0] = '0;
            assign row_free[r]  = chain[r][ENTRIES].free;
            assign row_unsub[r] = chain[r][ENTRIES].unsub;
            assign row_pub[r]   = chain[r][ENTRIES].pub;

            for (genvar e = 0; e < ENTRIES; e++)
            begin : g_cell
                tpsf_cell #(
                    .TOPIC_BYTES (TOPIC_BYTES)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl       (ctl[r]),
                    .data_byte (in_byte),
                    .pos       (pos_reg),
                    .pos_fin   (pos_fin),
                    .rd_addr   (rd_addr),
                    .chain_in  (chain[r][e]),
                    .chain_out (chain[r][e + 1])
                );
            end
        end
    endgenerate

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        if (msg_end)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= CMD_NONE;
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
            held_reg    <= '0;
            val_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_reg     <= cmd_next;
            pos_reg     <= pos_next;
            ovf_reg     <= ovf_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                val_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_end)
        begin
            m_data_reg <= {1'b0, status_fin, (cmd_fin == CMD_NONE) ? mask_vec : 4'd0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `TPSF_ASSERT_NOW(a_ovf_needs_cmd, !((cmd_reg == CMD_NONE) && ovf_reg))
    `TPSF_ASSERT_NOW(a_pos_range, pos_reg <= PW'(TOPIC_BYTES))
    `TPSF_ASSERT_NOW(a_ignore_no_topic, !((cmd_reg == CMD_IGNORE) && (pos_reg != '0)))
    `TPSF_ASSERT_NEXT(a_end_clears, msg_end, (cmd_reg == CMD_NONE) && (pos_reg == '0))
    `TPSF_ASSERT_NOW(a_ctrl_no_mask,
        !(m_valid_reg && (m_data_reg[6:4] != ST_PUBLISHED) && (m_data_reg[3:0] != 4'd0)))

endmodule

/* hdl/tpsf_cell.sv */
// -----------------------------------------------------------------------------
// Topic prefix filter cell
// One subscription slot: topic bytes, length, valid and running match flag.
// -----------------------------------------------------------------------------
module tpsf_cell
    import tpsf_pkg::*;
#(
    parameter int TOPIC_BYTES = TOPIC_BYTES_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  tpsf_ctl_t                               ctl,
    input  logic [7:0]                              data_byte,
    input  logic [$clog2(TOPIC_BYTES + 1) - 1:0]    pos,
    input  logic [$clog2(TOPIC_BYTES + 1) - 1:0]    pos_fin,
    input  logic [(TOPIC_BYTES > 1 ? $clog2(TOPIC_BYTES) : 1) - 1:0] rd_addr,
    input  tpsf_chain_t                             chain_in,
    output tpsf_chain_t                             chain_out
);

    localparam int PW = $clog2(TOPIC_BYTES + 1);
    localparam int AW = TOPIC_BYTES > 1 ? $clog2(TOPIC_BYTES) : 1;

    logic [7:0]    mem [TOPIC_BYTES];
    logic [7:0]    rd_reg;
    logic [PW-1:0] len_reg;
    logic          valid_reg, valid_next;
    logic          match_reg, match_next;
    logic          tgt_reg, tgt_next;

    logic          we;
    logic [AW-1:0] wr_addr;
    logic          differ;
    logic          match_now;
    logic          unsub_hit;
    logic          pub_hit;
    logic          pick;
    logic          drop;
    logic          take;

    assign wr_addr = pos[AW-1:0];
    assign we      = ctl.wr && tgt_reg;

    // read data is prefetched at the position the next word will use
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= data_byte;
        end
        if (we && (wr_addr == rd_addr))
        begin
            rd_reg <= data_byte;
        end
        else
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        if (pos >= len_reg)
        begin
            differ = ctl.exact;
        end
        else
        begin
            differ = (rd_reg != data_byte);
        end
        match_now = match_reg && !(ctl.cmp && valid_reg && differ);
        unsub_hit = valid_reg && match_now && (len_reg == pos_fin);
        pub_hit   = valid_reg && match_now && (len_reg <= pos_fin);
        pick      = ctl.pick && !valid_reg && !chain_in.free;
        drop      = ctl.commit_unsub && unsub_hit && !chain_in.unsub;
        take      = ctl.commit_sub && tgt_reg;

        chain_out.free  = chain_in.free  || !valid_reg;
        chain_out.unsub = chain_in.unsub || unsub_hit;
        chain_out.pub   = chain_in.pub   || pub_hit;

        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (drop)
        begin
            valid_next = 1'b0;
        end
        match_next = ctl.end_msg ? 1'b1 : match_now;
        tgt_next   = ctl.end_msg ? 1'b0 : (pick ? 1'b1 : tgt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b1;
            tgt_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            tgt_reg   <= tgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            len_reg <= pos_fin;
        end
    end

endmodule
